// File: sv/asd_pkg.sv
// Shared types and constants for the accelerometer stillness detector.
// No dependencies; imported by asd_axis_track and accel_stillness_detector.
package asd_pkg;

	// Field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned AXIS_W   = 16;
	localparam int unsigned COUNT_W  = 8;

	// Stream payload widths
	localparam int unsigned IN_DATA_W  = 6 * BYTE_W;
	localparam int unsigned OUT_BITS   = 6 * AXIS_W + 1;
	localparam int unsigned OUT_DATA_W = ((OUT_BITS + BYTE_W - 1) / BYTE_W) * BYTE_W;

	// Configuration port widths
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 16;

	// Register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MOVE_THRESHOLD    = 8'd0,
		REG_STILL_COUNT_LIMIT = 8'd1
	} cfg_reg_t;

	// Reset values
	localparam logic [AXIS_W-1:0]  MOVE_THRESHOLD_RST    = 16'd13;
	localparam logic [COUNT_W-1:0] STILL_COUNT_LIMIT_RST = 8'd5;
	localparam logic [COUNT_W-1:0] STILL_COUNT_MAX       = '1;

	// Per-axis status from the axis tracker to the top level
	typedef struct packed {
		logic [AXIS_W-1:0] change;
		logic              still;
	} axis_stat_t;

endpackage

// File: sv/asd_axis_track.sv
// One axis of the stillness detector: previous-sample register, absolute
// difference and threshold compare. Depends on asd_pkg.
module asd_axis_track (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  update,
	input  logic signed [asd_pkg::AXIS_W-1:0]     sample,
	input  logic        [asd_pkg::AXIS_W-1:0]     threshold,
	output asd_pkg::axis_stat_t                   stat
);
	import asd_pkg::*;

	logic signed [AXIS_W-1:0] prev_q;
	logic signed [AXIS_W:0]   diff;
	logic        [AXIS_W:0]   diff_abs;

	// Hold the last accepted sample; zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (update) begin
			prev_q <= sample;
		end
	end

	// Take the difference one bit wider so it cannot overflow, then fold the sign
	always_comb begin
		diff     = {sample[AXIS_W-1], sample} - {prev_q[AXIS_W-1], prev_q};
		diff_abs = diff[AXIS_W] ? (~diff + 1'b1) : diff;
	end

	assign stat.change = diff_abs[AXIS_W-1:0];
	assign stat.still  = (diff_abs[AXIS_W-1:0] < threshold);

endmodule

// File: sv/accel_stillness_detector.sv
// Top level of the accelerometer stillness detector: input register, three
// axis trackers, stillness counter and result register. Depends on asd_pkg
// and asd_axis_track.
//
// The block accepts one six-byte sample per clock while the output side is ready
// and returns one result per sample, through the input register and then the
// result register. The counter and the previous-sample registers update as a
// sample moves from the input register to the result register, so samples may
// follow each other in every cycle. A stalled result holds both registers;
// backpressure reaches s_tready in the same cycle. Configuration writes are
// always taken (cfg_ready is high) and unknown register indexes are ignored.
module accel_stillness_detector (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Sample input
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// from bit 0: x_low_byte, x_high_byte, y_low_byte, y_high_byte,
	// z_low_byte, z_high_byte
	input  logic [asd_pkg::IN_DATA_W-1:0]         s_tdata,
	// Result output
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// from bit 0: x_value, y_value, z_value, x_change, y_change, z_change,
	// stopped, zero fill
	output logic [asd_pkg::OUT_DATA_W-1:0]        m_tdata,
	// Configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [asd_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [asd_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import asd_pkg::*;

	logic [AXIS_W-1:0]     threshold_q;
	logic [COUNT_W-1:0]    limit_q;
	logic                  in_valid_s1;
	logic [IN_DATA_W-1:0]  in_data_s1;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [COUNT_W-1:0]    count_q;
	logic [COUNT_W-1:0]    count_next;
	logic                  out_free;
	logic                  advance;
	logic                  all_still;
	logic signed [AXIS_W-1:0] x_value;
	logic signed [AXIS_W-1:0] y_value;
	logic signed [AXIS_W-1:0] z_value;
	axis_stat_t            x_stat;
	axis_stat_t            y_stat;
	axis_stat_t            z_stat;
	logic                  stopped;
	logic [OUT_DATA_W-1:0] out_data_next;

	// Handshake: the result register frees up when empty or being drained
	assign out_free  = !out_valid_q || m_tready;
	assign advance   = in_valid_s1 && out_free;
	assign s_tready  = !in_valid_s1 || out_free;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= MOVE_THRESHOLD_RST;
			limit_q     <= STILL_COUNT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MOVE_THRESHOLD:    threshold_q <= cfg_data[AXIS_W-1:0];
				REG_STILL_COUNT_LIMIT: limit_q     <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: capture a request whenever the stage can move on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_data_s1 <= s_tdata;
		end
	end

	// Assemble little-endian axis values
	assign x_value = {in_data_s1[2*BYTE_W-1:BYTE_W],   in_data_s1[BYTE_W-1:0]};
	assign y_value = {in_data_s1[4*BYTE_W-1:3*BYTE_W], in_data_s1[3*BYTE_W-1:2*BYTE_W]};
	assign z_value = {in_data_s1[6*BYTE_W-1:5*BYTE_W], in_data_s1[5*BYTE_W-1:4*BYTE_W]};

	asd_axis_track u_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.update    (advance),
		.sample    (x_value),
		.threshold (threshold_q),
		.stat      (x_stat)
	);

	asd_axis_track u_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.update    (advance),
		.sample    (y_value),
		.threshold (threshold_q),
		.stat      (y_stat)
	);

	asd_axis_track u_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.update    (advance),
		.sample    (z_value),
		.threshold (threshold_q),
		.stat      (z_stat)
	);

	// Advance the saturating stillness counter, clear it on any movement
	always_comb begin
		all_still = x_stat.still && y_stat.still && z_stat.still;
		if (!all_still) begin
			count_next = '0;
		end else if (count_q == STILL_COUNT_MAX) begin
			count_next = count_q;
		end else begin
			count_next = count_q + 1'b1;
		end
		stopped = (count_next >= limit_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			count_q <= count_next;
		end
	end

	// Pack the result
	always_comb begin
		out_data_next = '0;
		out_data_next[OUT_BITS-1:0] = {stopped, z_stat.change, y_stat.change,
			x_stat.change, z_value, y_value, x_value};
	end

	// Result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= out_data_next;
		end
	end

	// Movement on any axis clears the counter
	a_clear_on_move: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !all_still) |=> (count_q == '0))
		else $error("still counter not cleared on movement");

	// Stillness below the ceiling adds exactly one
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && all_still && (count_q != STILL_COUNT_MAX))
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("still counter did not advance");

	// The stopped flag of a loaded result matches the updated counter
	a_stopped_flag: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (out_data_q[OUT_BITS-1] == (count_q >= limit_q)))
		else $error("stopped flag disagrees with still counter");

	// An empty result register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty result register");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for accel_stillness_detector: directed stimulus table,
// then random sample runs under several register settings and idle patterns.
// Depends on asd_pkg and the accel_stillness_detector RTL.
module tb_top;
	import asd_pkg::*;

	localparam int RESET_CYCLES = 6;
	localparam int DRAIN_CYCLES = 4;
	localparam int STALL_LIMIT  = 2000;
	localparam int MAX_REPORTS  = 10;

	// Indexes that map to no register
	localparam logic [CFG_INDEX_W-1:0] REG_NONE_LOW  = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_NONE_HIGH = 8'hFF;

	// Raw axis words, x in the low bits as on s_tdata
	typedef struct packed {
		logic [AXIS_W-1:0] z;
		logic [AXIS_W-1:0] y;
		logic [AXIS_W-1:0] x;
	} sample_t;

	// One result as packed on m_tdata, x_value in the low bits
	typedef struct packed {
		logic                     stopped;
		logic [AXIS_W-1:0]        dz;
		logic [AXIS_W-1:0]        dy;
		logic [AXIS_W-1:0]        dx;
		logic signed [AXIS_W-1:0] z;
		logic signed [AXIS_W-1:0] y;
		logic signed [AXIS_W-1:0] x;
	} motion_t;

	typedef struct {
		bit      typed;
		motion_t want;
	} plan_t;

	typedef struct {
		bit                     is_cfg;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0]  val;
		sample_t                smp;
		bit                     typed;
		motion_t                want;
	} script_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Predictor state and register copies
	sample_t            last_axes = '0;
	logic [COUNT_W-1:0] still_run = '0;
	logic [AXIS_W-1:0]  move_thr  = MOVE_THRESHOLD_RST;
	logic [COUNT_W-1:0] run_limit = STILL_COUNT_LIMIT_RST;

	plan_t       plan_q[$];
	motion_t     want_q[$];
	script_row_t script[$];

	int errors    = 0;
	int quiet     = 0;
	int send_idle = 18;
	int recv_idle = 71;

	accel_stillness_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Absolute difference of two signed axis words
	function automatic logic [AXIS_W-1:0] axis_gap(input logic [AXIS_W-1:0] now,
			input logic [AXIS_W-1:0] prev);
		logic [AXIS_W:0] d;
		d = {now[AXIS_W-1], now} - {prev[AXIS_W-1], prev};
		if (d[AXIS_W])
			d = -d;
		return d[AXIS_W-1:0];
	endfunction

	// Advance the stillness tracker by one sample and return its result
	function automatic motion_t track_motion(input sample_t smp);
		motion_t r;
		logic    all_still;
		r.x  = smp.x;
		r.y  = smp.y;
		r.z  = smp.z;
		r.dx = axis_gap(smp.x, last_axes.x);
		r.dy = axis_gap(smp.y, last_axes.y);
		r.dz = axis_gap(smp.z, last_axes.z);
		last_axes = smp;
		all_still = (r.dx < move_thr) && (r.dy < move_thr) && (r.dz < move_thr);
		if (!all_still)
			still_run = '0;
		else if (still_run != STILL_COUNT_MAX)
			still_run = still_run + 1'b1;
		r.stopped = (still_run >= run_limit);
		return r;
	endfunction

	function automatic sample_t axes(input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
			input logic [AXIS_W-1:0] z);
		sample_t s;
		s.x = x;
		s.y = y;
		s.z = z;
		return s;
	endfunction

	function automatic sample_t rand_sample();
		return sample_t'(48'({$urandom(), $urandom()}));
	endfunction

	// Move an axis word by a random step of at most span
	function automatic logic [AXIS_W-1:0] nudge(input logic [AXIS_W-1:0] w, input int span);
		int dlt;
		dlt = int'($urandom_range(span));
		if ($urandom_range(1) != 0)
			dlt = -dlt;
		return w + AXIS_W'(dlt);
	endfunction

	task automatic add_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		script_row_t row;
		row = '{is_cfg: 1'b1, idx: idx, val: val, smp: '0, typed: 1'b0, want: '0};
		script.push_back(row);
	endtask

	task automatic add_sample(input sample_t smp);
		script_row_t row;
		row = '{is_cfg: 1'b0, idx: '0, val: '0, smp: smp, typed: 1'b0, want: '0};
		script.push_back(row);
	endtask

	// Sample whose result is typed in: every change equal to d
	task automatic add_known(input sample_t smp, input logic [AXIS_W-1:0] d, input logic st);
		script_row_t row;
		motion_t     w;
		w = '{stopped: st, dz: d, dy: d, dx: d, z: smp.z, y: smp.y, x: smp.x};
		row = '{is_cfg: 1'b0, idx: '0, val: '0, smp: smp, typed: 1'b1, want: w};
		script.push_back(row);
	endtask

	// Offer one sample, with random idle cycles first; return at acceptance
	task automatic push_sample(input sample_t smp, input bit typed, input motion_t want);
		plan_t p;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			s_tdata  <= rand_sample();
			@(posedge clk);
		end
		p = '{typed: typed, want: want};
		plan_q.push_back(p);
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Write one register; leave cfg_valid high for a following write
	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Hold off new samples until every pending result has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (want_q.size() != 0 || plan_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random part: runs of small moves around a base, broken runs and noise
	task automatic run_segment(input int n_items, input logic [AXIS_W-1:0] thr);
		sample_t cur;
		sample_t smp;
		int      left;
		int      span;
		int      i;
		span = int'(thr);
		cur  = rand_sample();
		left = 0;
		for (i = 0; i < n_items; i++) begin
			if (i == n_items / 2)
				settle();
			if (left == 0 && $urandom_range(3) == 0) begin
				smp = rand_sample();
			end else begin
				if (left == 0) begin
					cur  = rand_sample();
					left = ($urandom_range(9) == 0) ? int'($urandom_range(300, 260))
						: int'($urandom_range(12, 1));
				end
				if ($urandom_range(19) == 0)
					cur = rand_sample();
				cur.x = nudge(cur.x, span);
				cur.y = nudge(cur.y, span);
				cur.z = nudge(cur.z, span);
				left--;
				smp = cur;
			end
			push_sample(smp, 1'b0, '0);
		end
	endtask

	// Track requests on all channels, predict, check results, drive m_tready
	always @(posedge clk) begin : monitor
		plan_t   plan;
		motion_t pred;
		motion_t got;
		motion_t exp_r;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MOVE_THRESHOLD:    move_thr  = cfg_data;
					REG_STILL_COUNT_LIMIT: run_limit = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				plan = plan_q.pop_front();
				pred = track_motion(sample_t'(s_tdata));
				want_q.push_back(plan.typed ? plan.want : pred);
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[OUT_BITS-1:0];
				if (want_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("tb: result with nothing pending: %h", got);
				end else begin
					exp_r = want_q.pop_front();
					if (got !== exp_r) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$write("tb: mismatch (expected/actual) x %0d/%0d y %0d/%0d z %0d/%0d",
								exp_r.x, got.x, exp_r.y, got.y, exp_r.z, got.z);
							$display(" dx %0d/%0d dy %0d/%0d dz %0d/%0d stopped %0b/%0b",
								exp_r.dx, got.dx, exp_r.dy, got.dy, exp_r.dz, got.dz,
								exp_r.stopped, got.stopped);
						end
					end
				end
			end
			quiet    <= ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) ? 0 : quiet + 1;
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		while (quiet < STALL_LIMIT)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		script_row_t        row;
		int                 k;
		int                 ph;
		int                 seg;
		int                 n;
		bit                 in_cfg;
		logic [AXIS_W-1:0]  thr;
		logic [COUNT_W-1:0] lim;

		// After reset, extremes, then the still run up to the limit
		add_known(axes(16'h0000, 16'h0000, 16'h0000), 16'h0000, 1'b0);
		add_known(axes(16'h7FFF, 16'h7FFF, 16'h7FFF), 16'h7FFF, 1'b0);
		add_known(axes(16'h8000, 16'h8000, 16'h8000), 16'hFFFF, 1'b0);
		add_sample(axes(16'h8000, 16'h8000, 16'h8000));
		add_sample(axes(16'h800C, 16'h8000, 16'h8000));
		add_sample(axes(16'h8000, 16'h800C, 16'h8000));
		add_sample(axes(16'h8000, 16'h8000, 16'h800C));
		add_sample(axes(16'h8000, 16'h8000, 16'h800C));
		// a change equal to the threshold counts as movement
		add_sample(axes(16'h8000, 16'h8000, 16'h8019));
		add_sample(axes(16'h00FF, 16'hFF00, 16'hFFFF));
		add_sample(axes(16'hFF00, 16'h00FF, 16'h0000));
		// zero threshold: nothing is ever still
		add_cfg(REG_MOVE_THRESHOLD, 16'h0000);
		add_sample(axes(16'hFF00, 16'h00FF, 16'h0000));
		add_sample(axes(16'hFF00, 16'h00FF, 16'h0000));
		// zero limit: stopped on every sample; upper data byte is dropped
		add_cfg(REG_STILL_COUNT_LIMIT, 16'hFF00);
		add_sample(axes(16'h7FFF, 16'h8000, 16'h1234));
		add_sample(axes(16'h7FFF, 16'h8000, 16'h1234));
		// unknown indexes leave both registers alone
		add_cfg(REG_NONE_LOW, 16'hFFFF);
		add_cfg(REG_NONE_HIGH, 16'h0000);
		add_cfg(REG_MOVE_THRESHOLD, 16'hFFFF);
		add_cfg(REG_STILL_COUNT_LIMIT, 16'h0001);
		add_sample(axes(16'h8000, 16'h7FFF, 16'h8000));
		add_sample(axes(16'h8000, 16'h7FFF, 16'h8000));
		add_sample(axes(16'h7FFF, 16'h8000, 16'h7FFF));
		add_cfg(REG_MOVE_THRESHOLD, MOVE_THRESHOLD_RST);
		add_cfg(REG_STILL_COUNT_LIMIT, 16'h00FF);
		add_sample(axes(16'h0001, 16'hFFFF, 16'h0000));
		add_sample(axes(16'hFFFF, 16'h0001, 16'h5555));
		add_sample(axes(16'hAAAA, 16'h5555, 16'hAAAA));
		add_cfg(REG_MOVE_THRESHOLD, MOVE_THRESHOLD_RST);
		add_cfg(REG_STILL_COUNT_LIMIT, {8'h00, STILL_COUNT_LIMIT_RST});
		add_sample(axes(16'h0000, 16'h0000, 16'h0000));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		in_cfg = 1'b0;
		for (k = 0; k < script.size(); k++) begin
			row = script[k];
			if (row.is_cfg) begin
				if (!in_cfg)
					settle();
				cfg_write(row.idx, row.val);
				in_cfg = 1'b1;
			end else begin
				if (in_cfg)
					cfg_valid <= 1'b0;
				in_cfg = 1'b0;
				push_sample(row.smp, row.typed, row.want);
			end
		end

		// Random segments, each under its own register setting
		for (ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 18 : (ph == 1) ? 71 : 0;
			recv_idle = (ph == 0) ? 71 : (ph == 1) ? 18 : 0;
			for (seg = 0; seg < 4; seg++) begin
				settle();
				n = 135;
				if (ph == 2 && seg == 3) begin
					// long still stretch to run the counter into saturation
					thr = 16'hFFFF;
					lim = STILL_COUNT_MAX;
					n   = 300;
				end else begin
					case ($urandom_range(5))
						0:       thr = 16'h0000;
						1:       thr = 16'h0001;
						2:       thr = MOVE_THRESHOLD_RST;
						3:       thr = AXIS_W'($urandom_range(64));
						4:       thr = 16'hFFFF;
						default: thr = AXIS_W'($urandom());
					endcase
					case ($urandom_range(5))
						0:       lim = 8'd0;
						1:       lim = 8'd1;
						2:       lim = STILL_COUNT_LIMIT_RST;
						3:       lim = STILL_COUNT_MAX;
						default: lim = COUNT_W'($urandom_range(12, 1));
					endcase
				end
				cfg_write(REG_MOVE_THRESHOLD, thr);
				if ($urandom_range(3) == 0)
					cfg_write(CFG_INDEX_W'($urandom_range(REG_NONE_HIGH, REG_NONE_LOW)),
						CFG_DATA_W'($urandom()));
				cfg_write(REG_STILL_COUNT_LIMIT, {8'($urandom_range(255)), lim});
				cfg_valid <= 1'b0;
				run_segment(n, thr);
			end
		end

		settle();
		if (errors == 0 && want_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
